### rtl/whtd_pkg.sv
`timescale 1ns / 1ps

package whtd_pkg;

  localparam int WINDOW_DEPTH = 30;
  localparam int SAMPLE_WIDTH = 16;

  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;
  localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ALPHA_W = 16;
  localparam int THR_W   = 15;
  localparam int HOLD_W  = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // filter value range: |y| < 2^(SAMPLE_WIDTH + ADDR_W + 1)
  localparam int Y_W    = SAMPLE_WIDTH + ADDR_W + 2;
  localparam int SUM_W  = Y_W + 1;
  localparam int PROD_W = SUM_W + ALPHA_W + 1;
  localparam int CMP_W  = ((Y_W > THR_W) ? Y_W : THR_W) + 1;

  localparam int OFF_W  = ((ADDR_W > HOLD_W) ? ADDR_W : HOLD_W) + 1;
  localparam int ADJ_W  = OFF_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(15834);
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(2304);
  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(10);

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_THR   = 2'd1,
    CFG_HOLD  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic              tap_detected;
    logic [AXIS_W-1:0] tap_axis;
  } result_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] pos;
    logic [AXIS_W-1:0] axis;
  } tag_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] pos;
    logic [AXIS_W-1:0] axis;
  } hit_t;

endpackage

### rtl/whtd_ram.sv
`timescale 1ns / 1ps

module whtd_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [whtd_pkg::ADDR_W-1:0] waddr_i,
  input  whtd_pkg::sample_t          wdata_i,
  input  logic                       re_i,
  input  logic [whtd_pkg::ADDR_W-1:0] raddr_i,
  output whtd_pkg::sample_t          rdata_o
);

  whtd_pkg::sample_t mem_q [whtd_pkg::WINDOW_DEPTH];
  whtd_pkg::sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/whtd_filter.sv
`timescale 1ns / 1ps

module whtd_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        flush_i,
  input  logic [whtd_pkg::ALPHA_W-1:0] alpha_i,
  input  logic [whtd_pkg::THR_W-1:0]   thr_i,
  input  whtd_pkg::tag_t              rd_tag_i,
  input  whtd_pkg::sample_t           rdata_i,
  output whtd_pkg::hit_t              hit_o
);

  localparam int SW = whtd_pkg::SAMPLE_WIDTH;
  localparam int YW = whtd_pkg::Y_W;
  localparam int AW = whtd_pkg::ALPHA_W;
  localparam int PW = whtd_pkg::PROD_W;
  localparam int MW = whtd_pkg::SUM_W;
  localparam int CW = whtd_pkg::CMP_W;
  localparam int TW = whtd_pkg::THR_W;

  whtd_pkg::tag_t s1_q, s2_q;
  whtd_pkg::tag_t s1_d, s2_d;
  logic signed [SW-1:0] xprev_q;
  logic signed [PW-1:0] prod_q;

  logic signed [SW-1:0] x;
  logic signed [YW-1:0] y;
  logic signed [MW-1:0] sum;
  logic signed [PW-1:0] prod_d;
  logic signed [CW-1:0] y_ext, thr_ext;

  always_comb begin
    case (s1_q.axis)
      whtd_pkg::AXIS_X: x = rdata_i.accel_x;
      whtd_pkg::AXIS_Y: x = rdata_i.accel_y;
      default:          x = rdata_i.accel_z;
    endcase
  end

  assign y   = prod_q[YW+AW-1:AW];
  assign sum = {y[YW-1], y}
             + {{(MW-SW){x[SW-1]}}, x}
             - {{(MW-SW){xprev_q[SW-1]}}, xprev_q};

  always_comb begin
    if (s1_q.pos == '0) begin
      prod_d = {{(PW-SW-AW){x[SW-1]}}, x, {AW{1'b0}}};
    end else begin
      prod_d = sum * $signed({1'b0, alpha_i});
    end
  end

  always_comb begin
    s1_d     = rd_tag_i;
    s1_d.vld = rd_tag_i.vld && !flush_i;
    s2_d     = s1_q;
    s2_d.vld = s1_q.vld && !flush_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.vld) begin
      prod_q  <= prod_d;
      xprev_q <= x;
    end
  end

  assign y_ext   = {{(CW-YW){y[YW-1]}}, y};
  assign thr_ext = {{(CW-TW){1'b0}}, thr_i};

  always_comb begin
    hit_o.vld  = s2_q.vld;
    hit_o.hit  = s2_q.vld && (s2_q.pos != '0) && (y_ext > thr_ext);
    hit_o.last = s2_q.vld && (s2_q.pos == whtd_pkg::ADDR_W'(whtd_pkg::WINDOW_DEPTH - 1))
              && (s2_q.axis == whtd_pkg::AXIS_Z);
    hit_o.pos  = s2_q.pos;
    hit_o.axis = s2_q.axis;
  end

endmodule

### rtl/windowed_highpass_tap_detector_top.sv
`timescale 1ns / 1ps

// Three-axis tap detector over a ring window of acceleration samples.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one sample item;
// output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
// result item per sample: tap flag and axis.
// The window lives in a one-port-read, one-port-write RAM with registered
// read data. An item that leaves the window short of full is only stored.
// Once full, the filter walks the window for x, y, z at one RAM read per
// cycle: 3*WINDOW_DEPTH reads, then the filter pipeline, a result step
// and the idle state. A tap stops the walk early; the ADJ state then
// wraps start + position + holdoff back into the window to set the new
// start.
// One item is in work at a time; in_ready_o is high only when idle.
// The result goes to an output register, so the next item is accepted while
// a result still waits; if the receiver stalls longer, the finished item
// waits in the last step until the output register frees up.
// Reset clears window start and fill count; the config registers return to
// their defaults. Config writes take effect at once and belong to idle time.
module windowed_highpass_tap_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  whtd_pkg::sample_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output whtd_pkg::result_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [whtd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [whtd_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int D  = whtd_pkg::WINDOW_DEPTH;
  localparam int AW = whtd_pkg::ADDR_W;
  localparam int FW = whtd_pkg::FILL_W;
  localparam int OW = whtd_pkg::OFF_W;
  localparam int JW = whtd_pkg::ADJ_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_ADJ  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] start_q, start_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          iss_act_q, iss_act_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic [whtd_pkg::AXIS_W-1:0] rd_axis_q, rd_axis_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [JW-1:0] wrap_q, wrap_d;
  logic          tap_q, tap_d;
  logic [whtd_pkg::AXIS_W-1:0] tap_axis_q, tap_axis_d;
  logic          out_vld_q, out_vld_d;
  whtd_pkg::result_t out_data_q, out_data_d;

  logic [whtd_pkg::ALPHA_W-1:0] alpha_q;
  logic [whtd_pkg::THR_W-1:0]   thr_q;
  logic [whtd_pkg::HOLD_W-1:0]  hold_q;

  logic              in_fire;
  logic [FW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     start_inc;
  logic              ram_we, ram_re;
  whtd_pkg::sample_t rdata;
  whtd_pkg::tag_t    rd_tag;
  whtd_pkg::hit_t    hit;
  logic              flush;
  logic [OW-1:0]     off;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign slot_sum  = {1'b0, FW'(start_q)} + {1'b0, fill_q};
  assign start_inc = (start_q == AW'(D - 1)) ? '0 : start_q + 1'b1;

  always_comb begin
    if (fill_q < FW'(D)) begin
      if (slot_sum >= (FW + 1)'(D)) begin
        slot = AW'(slot_sum - (FW + 1)'(D));
      end else begin
        slot = AW'(slot_sum);
      end
    end else begin
      slot = start_q;
    end
  end

  assign ram_we = in_fire;
  assign ram_re = iss_act_q;
  assign flush  = (state_q == S_RUN) && hit.hit;
  assign off    = OW'(hit.pos) + OW'(hold_q);

  always_comb begin
    rd_tag.vld  = iss_act_q;
    rd_tag.pos  = rd_pos_q;
    rd_tag.axis = rd_axis_q;
  end

  whtd_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (in_data_i),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  whtd_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (flush),
    .alpha_i  (alpha_q),
    .thr_i    (thr_q),
    .rd_tag_i (rd_tag),
    .rdata_i  (rdata),
    .hit_o    (hit)
  );

  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    fill_d     = fill_q;
    iss_act_d  = iss_act_q;
    rd_pos_d   = rd_pos_q;
    rd_axis_d  = rd_axis_q;
    rd_addr_d  = rd_addr_q;
    wrap_d     = wrap_q;
    tap_d      = tap_q;
    tap_axis_d = tap_axis_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_data_d = out_data_q;

    // read issue runs ahead of the filter pipeline
    if (iss_act_q) begin
      if (rd_pos_q == AW'(D - 1)) begin
        rd_pos_d  = '0;
        rd_addr_d = start_q;
        rd_axis_d = rd_axis_q + 1'b1;
        if (rd_axis_q == whtd_pkg::AXIS_Z) begin
          iss_act_d = 1'b0;
        end
      end else begin
        rd_pos_d  = rd_pos_q + 1'b1;
        rd_addr_d = (rd_addr_q == AW'(D - 1)) ? '0 : rd_addr_q + 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          tap_d      = 1'b0;
          tap_axis_d = whtd_pkg::AXIS_X;
          rd_pos_d   = '0;
          rd_axis_d  = whtd_pkg::AXIS_X;
          if (fill_q < FW'(D)) begin
            fill_d = fill_q + 1'b1;
            if (fill_q == FW'(D - 1)) begin
              state_d   = S_RUN;
              iss_act_d = 1'b1;
              rd_addr_d = start_q;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            start_d   = start_inc;
            state_d   = S_RUN;
            iss_act_d = 1'b1;
            rd_addr_d = start_inc;
          end
        end
      end
      S_RUN: begin
        if (hit.hit) begin
          iss_act_d  = 1'b0;
          tap_d      = 1'b1;
          tap_axis_d = hit.axis;
          wrap_d     = JW'(start_q) + JW'(off);
          fill_d     = (JW'(D) > JW'(off)) ? FW'(JW'(D) - JW'(off)) : '0;
          state_d    = S_ADJ;
        end else if (hit.last) begin
          state_d = S_DONE;
        end
      end
      S_ADJ: begin
        if (wrap_q >= JW'(D)) begin
          wrap_d = wrap_q - JW'(D);
        end else begin
          start_d = wrap_q[AW-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d               = 1'b1;
          out_data_d.tap_detected = tap_q;
          out_data_d.tap_axis     = tap_axis_q;
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= '0;
      fill_q    <= '0;
      iss_act_q <= 1'b0;
      out_vld_q <= 1'b0;
      tap_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      fill_q    <= fill_d;
      iss_act_q <= iss_act_d;
      out_vld_q <= out_vld_d;
      tap_q     <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q   <= rd_pos_d;
    rd_axis_q  <= rd_axis_d;
    rd_addr_q  <= rd_addr_d;
    wrap_q     <= wrap_d;
    tap_axis_q <= tap_axis_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= whtd_pkg::ALPHA_RST;
      thr_q   <= whtd_pkg::THR_RST;
      hold_q  <= whtd_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        whtd_pkg::CFG_ALPHA: alpha_q <= cfg_data_i[whtd_pkg::ALPHA_W-1:0];
        whtd_pkg::CFG_THR:   thr_q   <= cfg_data_i[whtd_pkg::THR_W-1:0];
        whtd_pkg::CFG_HOLD:  hold_q  <= cfg_data_i[whtd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ram write and read in the same cycle");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(D))
    else $error("fill count beyond window depth");

  a_start_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q < AW'(D))
    else $error("window start out of range");

  a_hit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit.vld |-> (state_q == S_RUN))
    else $error("filter output outside window pass");

  a_tap_adj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> (state_q == S_ADJ) && !iss_act_q)
    else $error("tap did not stop the window pass");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import whtd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam result_t NO_TAP = '0;
  localparam int RAND_ITEMS = 2000;
  localparam int N_SETTINGS = 7;
  localparam int TAIL_ITEMS = 150;
  localparam int LONG_STALL = 600;

  typedef struct {
    sample_t s;
    int      reps;
    bit      typed;
    result_t want;
  } dir_row_t;

  typedef struct {
    logic [CFG_W-1:0] alpha;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] hold;
  } setting_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sample_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  result_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  // shadow of the window and registers
  int                 win [WINDOW_DEPTH][AXES];
  int                 head;
  int                 fill;
  logic [ALPHA_W-1:0] m_alpha;
  logic [THR_W-1:0]   m_thr;
  logic [HOLD_W-1:0]  m_hold;

  result_t pending_taps [$];
  int      n_fail;
  int      n_items;
  int      n_checked;
  int      n_settings;
  int      n_taps [AXES];
  int      rest_base [AXES];
  int      src_pct;
  int      sink_pct;
  bit      tail;
  bit      stall_req;

  windowed_highpass_tap_detector_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_500_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic result_t predict_tap(input sample_t s);
    result_t r;
    int      slot;
    int      off;
    bit      hit;
    longint  xp;
    longint  yp;
    longint  xv;
    longint  yv;
    r = NO_TAP;
    hit = 1'b0;
    if (fill < WINDOW_DEPTH) begin
      slot = (head + fill) % WINDOW_DEPTH;
      fill++;
    end else begin
      slot = head;
      head = (head + 1) % WINDOW_DEPTH;
    end
    win[slot][0] = $signed(s.accel_x);
    win[slot][1] = $signed(s.accel_y);
    win[slot][2] = $signed(s.accel_z);
    if (fill == WINDOW_DEPTH) begin
      for (int a = 0; a < AXES && !hit; a++) begin
        xp = win[head][a];
        yp = xp;
        for (int i = 1; i < WINDOW_DEPTH && !hit; i++) begin
          xv = win[(head + i) % WINDOW_DEPTH][a];
          yv = (longint'(m_alpha) * (yp + xv - xp)) >>> 16;
          xp = xv;
          yp = yv;
          if (yv > longint'(m_thr)) begin
            hit = 1'b1;
            r.tap_detected = 1'b1;
            r.tap_axis = AXIS_W'(a);
            off = i + int'(m_hold);
            head = (head + off) % WINDOW_DEPTH;
            fill = (fill > off) ? fill - off : 0;
          end
        end
      end
    end
    return r;
  endfunction

  // mostly sensor at rest with small noise, some steps, some raw noise
  function automatic sample_t make_sample();
    sample_t s;
    int      v [AXES];
    int      pick;
    int      ax;
    int      jump;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s = 48'({$urandom(), $urandom()});
      return s;
    end
    foreach (v[a]) v[a] = rest_base[a] + int'($urandom_range(0, 128)) - 64;
    if (pick < 24) begin
      ax = $urandom_range(0, AXES - 1);
      jump = $urandom_range(1000, 16000);
      v[ax] += ($urandom_range(0, 1) != 0) ? jump : -jump;
    end
    s.accel_x = 16'(v[0]);
    s.accel_y = 16'(v[1]);
    s.accel_z = 16'(v[2]);
    return s;
  endfunction

  task automatic send_sample(input sample_t s, input bit typed, input result_t want);
    result_t got;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    got = predict_tap(s);
    pending_taps.push_back(typed ? want : got);
    n_items++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (pending_taps.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ALPHA: m_alpha = val[ALPHA_W-1:0];
      CFG_THR:   m_thr   = val[THR_W-1:0];
      CFG_HOLD:  m_hold  = val[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t c);
    drain();
    write_reg(CFG_ALPHA, c.alpha);
    write_reg(CFG_THR, c.thr);
    write_reg(CFG_HOLD, c.hold);
    write_reg(CFG_SPARE, CFG_W'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_taps.size() == 0) begin
        $error("result item with nothing expected: tap_detected %0d tap_axis %0d",
               out_data.tap_detected, out_data.tap_axis);
        n_fail++;
      end else begin
        want = pending_taps.pop_front();
        if (out_data.tap_detected !== want.tap_detected) begin
          $error("tap_detected expected %0d actual %0d", want.tap_detected,
                 out_data.tap_detected);
          n_fail++;
        end
        if (out_data.tap_axis !== want.tap_axis) begin
          $error("tap_axis expected %0d actual %0d", want.tap_axis, out_data.tap_axis);
          n_fail++;
        end
        if (want.tap_detected) n_taps[want.tap_axis]++;
        n_checked++;
      end
    end
  end

  initial begin : sink_side
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!tail && $urandom_range(0, 99) < sink_pct) begin
        gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows [5];
    setting_t cfgs [N_SETTINGS];
    int       per_phase;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_ALPHA;
    cfg_data = '0;
    head     = 0;
    fill     = 0;
    m_alpha  = ALPHA_RST;
    m_thr    = THR_RST;
    m_hold   = HOLD_RST;
    foreach (win[i, j]) win[i][j] = 0;
    foreach (n_taps[a]) n_taps[a] = 0;
    foreach (rest_base[a]) rest_base[a] = 0;
    n_fail     = 0;
    n_items    = 0;
    n_checked  = 0;
    n_settings = 0;
    src_pct    = 20;
    sink_pct   = 20;
    tail       = 1'b0;
    stall_req  = 1'b0;

    // fill to one short of full, then a late x tap whose holdoff runs past the
    // window; refill after the tap and finish with a z step at the newest slot
    rows = '{
      '{'{16'sh0000, 16'sh0000, 16'sh0000}, 28, 1'b1, NO_TAP},
      '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1, 1'b1, NO_TAP},
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1, 1'b0, NO_TAP},
      '{'{16'sh0000, 16'sh0000, 16'sh0000}, 29, 1'b1, NO_TAP},
      '{'{16'sh0000, 16'sh0000, 16'sh7fff}, 1, 1'b0, NO_TAP}
    };

    cfgs[0] = '{16'hffff, 16'h0000, 16'h0000};
    cfgs[1] = '{16'h0000, 16'h7fff, 16'h003f};
    cfgs[2] = '{16'd15834, 16'h8900, 16'hffca};
    for (int p = 3; p < N_SETTINGS; p++) begin
      cfgs[p].alpha = CFG_W'($urandom_range(4000, 60000));
      cfgs[p].thr   = {1'($urandom()), 15'($urandom_range(300, 6000))};
      cfgs[p].hold  = CFG_W'($urandom());
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      repeat (rows[r].reps) send_sample(rows[r].s, rows[r].typed, rows[r].want);
    end

    per_phase = RAND_ITEMS / N_SETTINGS;
    for (int p = 0; p < N_SETTINGS; p++) begin
      apply_setting(cfgs[p]);
      foreach (rest_base[a]) rest_base[a] = int'($urandom_range(0, 6000)) - 3000;
      src_pct  = ($urandom_range(0, 3) == 0) ? 0 : 20;
      sink_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      for (int k = 0; k < per_phase; k++) begin
        if (p == N_SETTINGS - 1 && k >= per_phase - TAIL_ITEMS) tail = 1'b1;
        if (p == 3 && k == 40) stall_req = 1'b1;
        if (!tail && $urandom_range(0, 99) < src_pct) idle_input($urandom_range(1, 13));
        send_sample(make_sample(), 1'b0, NO_TAP);
      end
    end

    drain();
    repeat (100) @(posedge clk);

    $display("%0d sample items sent, %0d results checked across %0d register settings",
             n_items, n_checked, n_settings);
    $display("taps reported on x %0d, y %0d, z %0d",
             n_taps[AXIS_X], n_taps[AXIS_Y], n_taps[AXIS_Z]);
    if (n_fail == 0 && pending_taps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
